### hdl/utd_pkg.sv
// shared types, constants and helpers of the utf-8 to utf-16 decoder
`default_nettype none

package utd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;
    localparam logic [15:0] HIGH_SURROGATE_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURROGATE_BASE = 16'hDC00;

    // lead byte length codes
    localparam logic [2:0] LEAD_BAD = 3'd0;
    localparam logic [2:0] LEAD_ONE = 3'd1;
    localparam logic [2:0] LEAD_TWO = 3'd2;
    localparam logic [2:0] LEAD_THREE = 3'd3;
    localparam logic [2:0] LEAD_FOUR = 3'd4;

    // up to three code units produced by one byte, first unit in slot 0
    typedef struct packed {
        logic [2:0][15:0] units;
        logic [1:0]       n;
        logic             eob;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    function automatic logic [2:0] lead_len(input logic [7:0] c);
        logic [2:0] k;
        if (c[7] == 1'b0)
        begin
            k = LEAD_ONE;
        end
        else if ((c & 8'hE0) == 8'hC0)
        begin
            k = LEAD_TWO;
        end
        else if ((c & 8'hF0) == 8'hE0)
        begin
            k = LEAD_THREE;
        end
        else if ((c & 8'hF8) == 8'hF0)
        begin
            k = LEAD_FOUR;
        end
        else
        begin
            k = LEAD_BAD;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

### hdl/utd_byte_if.sv
// byte channel of the decoder
`default_nettype none

interface utd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_buffer;

    modport source (output valid, output byte_in, output end_of_buffer, input ready);
    modport sink (input valid, input byte_in, input end_of_buffer, output ready);
endinterface

`default_nettype wire

### hdl/utd_unit_if.sv
// code unit channel of the decoder
`default_nettype none

interface utd_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        end_of_run;
    logic        buffer_done;

    modport source (output valid, output code_unit, output end_of_run, output buffer_done,
                    input ready);
    modport sink (input valid, input code_unit, input end_of_run, input buffer_done,
                  output ready);
endinterface

`default_nettype wire

### hdl/utd_front.sv
// front end: sequence tracking and decoding of each byte into a job of code units
`default_nettype none

module utd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    byte_in,
    input  wire logic          end_of_buffer,
    output utd_pkg::push_t     push
);
    import utd_pkg::*;

    logic [2:0][7:0] pend_reg, pend_next;
    logic [1:0]      pcnt_reg, pcnt_next;
    logic [2:0]      slen_reg, slen_next;

    logic [2:0]  b_len;
    logic [2:0]  p1_len;
    logic [20:0] cp;
    logic [20:0] v;
    logic [15:0] b_single;

    always_comb
    begin
        b_len = lead_len(byte_in);
        p1_len = lead_len(pend_reg[1]);
        b_single = (b_len == LEAD_ONE) ? {8'h00, byte_in} : REPLACEMENT_UNIT;

        // assemble the code point of a completed sequence
        case (slen_reg)
            LEAD_TWO:   cp = {10'b0, pend_reg[0][4:0], byte_in[5:0]};
            LEAD_THREE: cp = {5'b0, pend_reg[0][3:0], pend_reg[1][5:0], byte_in[5:0]};
            default:    cp = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0],
                              byte_in[5:0]};
        endcase
        v = cp - SUPPLEMENTARY_BASE;

        push = '0;
        pend_next = pend_reg;
        pcnt_next = pcnt_reg;
        slen_next = slen_reg;

        if (accept)
        begin
            if (slen_reg == LEAD_BAD)
            begin
                if (b_len == LEAD_ONE || b_len == LEAD_BAD || end_of_buffer)
                begin
                    push.valid = 1'b1;
                    push.job.units[0] = b_single;
                    push.job.n = 2'd1;
                end
                else
                begin
                    pend_next[0] = byte_in;
                    pcnt_next = 2'd1;
                    slen_next = b_len;
                end
            end
            else if ({1'b0, pcnt_reg} + 3'd1 == slen_reg)
            begin
                push.valid = 1'b1;
                if (cp[20:16] != 5'd0)
                begin
                    push.job.units[0] = HIGH_SURROGATE_BASE + {5'b0, v[20:10]};
                    push.job.units[1] = LOW_SURROGATE_BASE + {6'b0, v[9:0]};
                    push.job.n = 2'd2;
                end
                else
                begin
                    push.job.units[0] = cp[15:0];
                    push.job.n = 2'd1;
                end
                pcnt_next = 2'd0;
                slen_next = LEAD_BAD;
            end
            else if (end_of_buffer)
            begin
                // cut-off sequence: lead gives a replacement, the held tail is redone
                push.valid = 1'b1;
                push.job.units[0] = REPLACEMENT_UNIT;
                if (pcnt_reg == 2'd1)
                begin
                    push.job.units[1] = b_single;
                    push.job.n = 2'd2;
                end
                else if (p1_len == LEAD_TWO)
                begin
                    push.job.units[1] = {5'b0, pend_reg[1][4:0], byte_in[5:0]};
                    push.job.n = 2'd2;
                end
                else
                begin
                    push.job.units[1] = (p1_len == LEAD_ONE) ? {8'h00, pend_reg[1]}
                                                             : REPLACEMENT_UNIT;
                    push.job.units[2] = b_single;
                    push.job.n = 2'd3;
                end
            end
            else
            begin
                case (pcnt_reg)
                    2'd1:    pend_next[1] = byte_in;
                    default: pend_next[2] = byte_in;
                endcase
                pcnt_next = pcnt_reg + 2'd1;
            end

            if (end_of_buffer)
            begin
                pcnt_next = 2'd0;
                slen_next = LEAD_BAD;
            end
        end
        push.job.eob = end_of_buffer;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg <= 2'd0;
            slen_reg <= LEAD_BAD;
        end
        else
        begin
            pcnt_reg <= pcnt_next;
            slen_reg <= slen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

### hdl/utd_queue.sv
// job queue between front and back
`default_nettype none

module utd_queue #(
    parameter int DEPTH = utd_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire utd_pkg::push_t push,
    output logic               full,
    input  wire logic          pop,
    output utd_pkg::job_t      head,
    output logic               empty
);
    import utd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    logic do_push, do_pop;

    assign full = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head = mem_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop = pop && !empty;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CW'(1);
                2'b01:   count_reg <= count_reg - CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

`default_nettype wire

### hdl/utd_back.sv
// back end: queue head to output register, one code unit per unstalled cycle
`default_nettype none

module utd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire utd_pkg::job_t head,
    input  wire logic          empty,
    output logic               pop,
    utd_unit_if.source         units
);
    import utd_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    logic        ovalid_reg, ovalid_next;
    logic [15:0] unit_reg, unit_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;

    logic load, last;

    assign load = !ovalid_reg || units.ready;
    assign last = (idx_reg == head.n - 2'd1);

    always_comb
    begin
        idx_next = idx_reg;
        ovalid_next = ovalid_reg;
        unit_next = unit_reg;
        run_next = run_reg;
        done_next = done_reg;
        pop = 1'b0;
        if (load)
        begin
            ovalid_next = !empty;
            if (!empty)
            begin
                case (idx_reg)
                    2'd0:    unit_next = head.units[0];
                    2'd1:    unit_next = head.units[1];
                    default: unit_next = head.units[2];
                endcase
                run_next = last;
                done_next = last && head.eob;
                if (last)
                begin
                    pop = 1'b1;
                    idx_next = 2'd0;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
        run_reg <= run_next;
        done_reg <= done_next;
    end

    assign units.valid = ovalid_reg;
    assign units.code_unit = unit_reg;
    assign units.end_of_run = run_reg;
    assign units.buffer_done = done_reg;

endmodule

`default_nettype wire

### hdl/utf8_to_utf16_stream_decoder.sv
// top level of the utf-8 to utf-16 stream decoder
//
//  channel       dir  word                                        handshake
//  byte_stream   in   byte_in[7:0], end_of_buffer                 valid/ready
//  unit_stream   out  code_unit[15:0], end_of_run, buffer_done    valid/ready
//
// one byte is taken each cycle while the job queue has room; a byte costs
// zero to three code units, and the back end sends one code unit per cycle
// while a job waits and the output is accepted, so the back end sets the pace
// a code unit is registered in the queue, then in the output register
// asynchronous reset closes any open sequence and empties queue and output
// either side may stall alone: the queue soaks up QUEUE_DEPTH jobs
`default_nettype none

module utf8_to_utf16_stream_decoder #(
    parameter int QUEUE_DEPTH = utd_pkg::QUEUE_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    utd_byte_if.sink   byte_stream,
    utd_unit_if.source unit_stream
);
    import utd_pkg::*;

    push_t push;
    job_t  head;
    logic  full;
    logic  empty;
    logic  pop;
    logic  accept;

    // bytes flow in whenever the queue can take a job
    assign byte_stream.ready = !full;
    assign accept = byte_stream.valid && !full;

    // front: lead byte classification, held bytes, code point assembly
    utd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .byte_in       (byte_stream.byte_in),
        .end_of_buffer (byte_stream.end_of_buffer),
        .push          (push)
    );

    // decoupling queue of decoded jobs
    utd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .pop   (pop),
        .head  (head),
        .empty (empty)
    );

    // back: serialises each job into single code units with run flags
    utd_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .units (unit_stream)
    );

endmodule

`default_nettype wire

### hdl/utd_checker.sv
// port-level checks of the decoder and their bind
`default_nettype none

module utd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] code_unit,
    input wire logic        end_of_run,
    input wire logic        buffer_done
);

    logic seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            seen_reg <= 1'b1;
        end
    end

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid &&
            $stable({code_unit, end_of_run, buffer_done})))
        else $error("stalled code unit changed");

    // end of buffer only marks the last unit of a run
    a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!buffer_done || end_of_run))
        else $error("buffer_done without end_of_run");

    // nothing leaves before a byte has come in
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_reg)
        else $error("code unit before any byte");

    // no code unit appears while no byte has been taken yet
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (!seen_reg && !(in_valid && in_ready)) |=> !out_valid)
        else $error("code unit too early");

endmodule

bind utf8_to_utf16_stream_decoder utd_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (byte_stream.valid),
    .in_ready    (byte_stream.ready),
    .out_valid   (unit_stream.valid),
    .out_ready   (unit_stream.ready),
    .code_unit   (unit_stream.code_unit),
    .end_of_run  (unit_stream.end_of_run),
    .buffer_done (unit_stream.buffer_done)
);

`default_nettype wire
